>>> rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared widths, types, sector codes and the sector-to-channel mapping for
// the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int HUE_WIDTH_DEF       = 16;
    localparam int LEVEL_FRAC_BITS_DEF = 8;
    localparam int COLOR_WIDTH         = 8;
    localparam int SECTOR_WIDTH        = 3;

    typedef logic [SECTOR_WIDTH-1:0] t_sector;
    typedef logic [COLOR_WIDTH-1:0]  t_color;

    localparam t_sector SECT_RED_YELLOW    = 3'd0;
    localparam t_sector SECT_YELLOW_GREEN  = 3'd1;
    localparam t_sector SECT_GREEN_CYAN    = 3'd2;
    localparam t_sector SECT_CYAN_BLUE     = 3'd3;
    localparam t_sector SECT_BLUE_MAGENTA  = 3'd4;

    // which level feeds a channel
    typedef enum logic [1:0] {
        SRC_HI,
        SRC_LO,
        SRC_UP,
        SRC_DOWN
    } t_src;

    typedef struct packed {
        t_src red;
        t_src green;
        t_src blue;
    } t_src_sel;

    function automatic t_src_sel sector_sources(t_sector sector);
        t_src_sel sel;
        unique case (sector)
            SECT_RED_YELLOW: begin
                sel = '{red: SRC_HI, green: SRC_UP, blue: SRC_LO};
            end
            SECT_YELLOW_GREEN: begin
                sel = '{red: SRC_DOWN, green: SRC_HI, blue: SRC_LO};
            end
            SECT_GREEN_CYAN: begin
                sel = '{red: SRC_LO, green: SRC_HI, blue: SRC_UP};
            end
            SECT_CYAN_BLUE: begin
                sel = '{red: SRC_LO, green: SRC_DOWN, blue: SRC_HI};
            end
            SECT_BLUE_MAGENTA: begin
                sel = '{red: SRC_UP, green: SRC_LO, blue: SRC_HI};
            end
            // magenta to red sector
            default: begin
                sel = '{red: SRC_HI, green: SRC_LO, blue: SRC_DOWN};
            end
        endcase
        return sel;
    endfunction

endpackage

>>> rtl/hsvrgb_hsv_if.sv
// ----------------------------------------------------------------------------
// hsvrgb_hsv_if
// Request channel carrying one hue, saturation and brightness item.
// ----------------------------------------------------------------------------
interface hsvrgb_hsv_if #(
    parameter int HUE_WIDTH       = hsvrgb_pkg::HUE_WIDTH_DEF,
    parameter int LEVEL_FRAC_BITS = hsvrgb_pkg::LEVEL_FRAC_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic        [HUE_WIDTH-1:0]       hue_turn;
    logic signed [LEVEL_FRAC_BITS+1:0] saturation;
    logic signed [LEVEL_FRAC_BITS+1:0] brightness;

    modport source (output valid, hue_turn, saturation, brightness, input ready);
    modport sink   (input valid, hue_turn, saturation, brightness, output ready);
endinterface

>>> rtl/hsvrgb_rgb_if.sv
// ----------------------------------------------------------------------------
// hsvrgb_rgb_if
// Request channel carrying one 8-bit RGB triple.
// ----------------------------------------------------------------------------
interface hsvrgb_rgb_if;
    import hsvrgb_pkg::*;

    logic   valid;
    logic   ready;
    t_color red;
    t_color green;
    t_color blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Converts a hue, saturation and brightness request into one 8-bit RGB
// triple. Hue is a fraction of a full turn and wraps; saturation and
// brightness are signed fixed point, clamped to 0..1.0. Every result is
// exact: floor(255 * channel). The block takes one request per clock while
// the pipeline has room, and has five register stages, one each for the
// clamp and sector split, the brightness times saturation multiply, the
// ramp multiplies, the channel routing, and the 255 scaling that feeds the
// output register. Valid bits travel with the data, so a stalled output
// only blocks the input once all five stages hold a request.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit #(
    parameter int HUE_WIDTH       = hsvrgb_pkg::HUE_WIDTH_DEF,
    parameter int LEVEL_FRAC_BITS = hsvrgb_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsvrgb_hsv_if.sink    i_hsv,
    hsvrgb_rgb_if.source  o_rgb
);
    import hsvrgb_pkg::*;

    localparam int CW = LEVEL_FRAC_BITS + 1;
    localparam int NW = 2*LEVEL_FRAC_BITS + HUE_WIDTH + 1;
    localparam logic [CW-1:0] LVL_ONE = CW'(1) << LEVEL_FRAC_BITS;

    logic                 w_prep_valid;
    logic                 w_prep_ready;
    t_sector              w_prep_sector;
    logic [HUE_WIDTH-1:0] w_prep_frac;
    logic [CW-1:0]        w_prep_sat;
    logic [CW-1:0]        w_prep_bri;

    logic                 w_ramp_valid;
    logic                 w_ramp_ready;
    t_sector              w_ramp_sector;
    logic [CW-1:0]        w_ramp_bri;
    logic [2*CW-1:0]      w_ramp_vs;
    logic [NW-1:0]        w_ramp_prod_up;
    logic [NW-1:0]        w_ramp_prod_down;

    hsvrgb_prep #(
        .HUE_WIDTH       (HUE_WIDTH),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_hsv.valid),
        .o_ready  (i_hsv.ready),
        .i_hue    (i_hsv.hue_turn),
        .i_sat    ($unsigned(i_hsv.saturation)),
        .i_bri    ($unsigned(i_hsv.brightness)),
        .o_valid  (w_prep_valid),
        .i_ready  (w_prep_ready),
        .o_sector (w_prep_sector),
        .o_frac   (w_prep_frac),
        .o_sat    (w_prep_sat),
        .o_bri    (w_prep_bri)
    );

    hsvrgb_ramp #(
        .HUE_WIDTH       (HUE_WIDTH),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_ramp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_prep_valid),
        .o_ready     (w_prep_ready),
        .i_sector    (w_prep_sector),
        .i_frac      (w_prep_frac),
        .i_sat       (w_prep_sat),
        .i_bri       (w_prep_bri),
        .o_valid     (w_ramp_valid),
        .i_ready     (w_ramp_ready),
        .o_sector    (w_ramp_sector),
        .o_bri       (w_ramp_bri),
        .o_vs        (w_ramp_vs),
        .o_prod_up   (w_ramp_prod_up),
        .o_prod_down (w_ramp_prod_down)
    );

    hsvrgb_mix #(
        .HUE_WIDTH       (HUE_WIDTH),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_ramp_valid),
        .o_ready     (w_ramp_ready),
        .i_sector    (w_ramp_sector),
        .i_bri       (w_ramp_bri),
        .i_vs        (w_ramp_vs),
        .i_prod_up   (w_ramp_prod_up),
        .i_prod_down (w_ramp_prod_down),
        .o_valid     (o_rgb.valid),
        .i_ready     (o_rgb.ready),
        .o_red       (o_rgb.red),
        .o_green     (o_rgb.green),
        .o_blue      (o_rgb.blue)
    );

    // input backs off only when every stage is full and the output is held
    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_hsv.ready |-> (o_rgb.valid && !o_rgb.ready)
    ) else $error("input stalled while pipeline has room");

    a_accept_enters_pipe: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_hsv.valid && i_hsv.ready) |=> w_prep_valid
    ) else $error("accepted request did not enter the first stage");

    a_levels_clamped: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_prep_valid |-> (w_prep_sat <= LVL_ONE && w_prep_bri <= LVL_ONE)
    ) else $error("clamped level above one");
endmodule

>>> rtl/hsvrgb_prep.sv
// ----------------------------------------------------------------------------
// hsvrgb_prep
// First pipeline stage: clamps saturation and brightness to 0..1.0 and
// splits hue times six into a sector number and a fraction.
// ----------------------------------------------------------------------------
module hsvrgb_prep #(
    parameter int HUE_WIDTH       = hsvrgb_pkg::HUE_WIDTH_DEF,
    parameter int LEVEL_FRAC_BITS = hsvrgb_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [HUE_WIDTH-1:0]         i_hue,
    input  logic [LEVEL_FRAC_BITS+1:0]   i_sat,
    input  logic [LEVEL_FRAC_BITS+1:0]   i_bri,
    output logic                         o_valid,
    input  logic                         i_ready,
    output hsvrgb_pkg::t_sector          o_sector,
    output logic [HUE_WIDTH-1:0]         o_frac,
    output logic [LEVEL_FRAC_BITS:0]     o_sat,
    output logic [LEVEL_FRAC_BITS:0]     o_bri
);
    import hsvrgb_pkg::*;

    localparam int LW = LEVEL_FRAC_BITS + 2;
    localparam int CW = LEVEL_FRAC_BITS + 1;
    localparam logic [CW-1:0] LVL_ONE = CW'(1) << LEVEL_FRAC_BITS;

    function automatic logic [CW-1:0] clamp_level(logic [LW-1:0] raw);
        logic [CW-1:0] lvl;
        priority if (raw[LW-1]) begin
            lvl = '0;
        end else if (raw[LW-2:0] > LVL_ONE) begin
            lvl = LVL_ONE;
        end else begin
            lvl = raw[LW-2:0];
        end
        return lvl;
    endfunction

    logic [HUE_WIDTH+2:0] n_h6;
    logic [CW-1:0]        n_sat;
    logic [CW-1:0]        n_bri;

    logic                 r_valid;
    t_sector              r_sector;
    logic [HUE_WIDTH-1:0] r_frac;
    logic [CW-1:0]        r_sat;
    logic [CW-1:0]        r_bri;

    // hue * 6 as two shifted adds
    assign n_h6  = ({3'b000, i_hue} << 2) + ({3'b000, i_hue} << 1);
    assign n_sat = clamp_level(i_sat);
    assign n_bri = clamp_level(i_bri);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sector <= n_h6[HUE_WIDTH+2:HUE_WIDTH];
            r_frac   <= n_h6[HUE_WIDTH-1:0];
            r_sat    <= n_sat;
            r_bri    <= n_bri;
        end
    end

    assign o_valid  = r_valid;
    assign o_sector = r_sector;
    assign o_frac   = r_frac;
    assign o_sat    = r_sat;
    assign o_bri    = r_bri;
endmodule

>>> rtl/hsvrgb_ramp.sv
// ----------------------------------------------------------------------------
// hsvrgb_ramp
// Two multiplier stages: brightness times saturation, then that product
// times the sector fraction and its complement for the two ramp channels.
// ----------------------------------------------------------------------------
module hsvrgb_ramp #(
    parameter int HUE_WIDTH       = hsvrgb_pkg::HUE_WIDTH_DEF,
    parameter int LEVEL_FRAC_BITS = hsvrgb_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  hsvrgb_pkg::t_sector                         i_sector,
    input  logic [HUE_WIDTH-1:0]                        i_frac,
    input  logic [LEVEL_FRAC_BITS:0]                    i_sat,
    input  logic [LEVEL_FRAC_BITS:0]                    i_bri,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output hsvrgb_pkg::t_sector                         o_sector,
    output logic [LEVEL_FRAC_BITS:0]                    o_bri,
    output logic [2*LEVEL_FRAC_BITS+1:0]                o_vs,
    output logic [2*LEVEL_FRAC_BITS+HUE_WIDTH:0]        o_prod_up,
    output logic [2*LEVEL_FRAC_BITS+HUE_WIDTH:0]        o_prod_down
);
    import hsvrgb_pkg::*;

    localparam int CW = LEVEL_FRAC_BITS + 1;
    localparam int NW = 2*LEVEL_FRAC_BITS + HUE_WIDTH + 1;
    localparam logic [HUE_WIDTH:0] HUE_FULL = (HUE_WIDTH+1)'(1) << HUE_WIDTH;

    // first stage: v*s and H-f
    logic [2*CW-1:0]      n_a_vs;
    logic [HUE_WIDTH:0]   n_a_cofrac;
    logic                 w_a_ready;
    logic                 r_a_valid;
    t_sector              r_a_sector;
    logic [CW-1:0]        r_a_bri;
    logic [2*CW-1:0]      r_a_vs;
    logic [HUE_WIDTH-1:0] r_a_frac;
    logic [HUE_WIDTH:0]   r_a_cofrac;

    // second stage: ramp products
    logic [2*CW+HUE_WIDTH-1:0] n_b_down_full;
    logic [2*CW+HUE_WIDTH:0]   n_b_up_full;
    logic                      w_b_ready;
    logic                      r_b_valid;
    t_sector                   r_b_sector;
    logic [CW-1:0]             r_b_bri;
    logic [2*CW-1:0]           r_b_vs;
    logic [NW-1:0]             r_b_prod_up;
    logic [NW-1:0]             r_b_prod_down;

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    assign n_a_vs     = i_sat * i_bri;
    assign n_a_cofrac = HUE_FULL - {1'b0, i_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_sector <= i_sector;
            r_a_bri    <= i_bri;
            r_a_vs     <= n_a_vs;
            r_a_frac   <= i_frac;
            r_a_cofrac <= n_a_cofrac;
        end
    end

    // both products are at most 2^(NW-1), so the top bits are dropped
    assign n_b_down_full = r_a_vs * r_a_frac;
    assign n_b_up_full   = r_a_vs * r_a_cofrac;

    always_ff @(posedge i_clk) begin
        if (w_b_ready && r_a_valid) begin
            r_b_sector    <= r_a_sector;
            r_b_bri       <= r_a_bri;
            r_b_vs        <= r_a_vs;
            r_b_prod_up   <= n_b_up_full[NW-1:0];
            r_b_prod_down <= n_b_down_full[NW-1:0];
        end
    end

    assign o_valid     = r_b_valid;
    assign o_sector    = r_b_sector;
    assign o_bri       = r_b_bri;
    assign o_vs        = r_b_vs;
    assign o_prod_up   = r_b_prod_up;
    assign o_prod_down = r_b_prod_down;
endmodule

>>> rtl/hsvrgb_mix.sv
// ----------------------------------------------------------------------------
// hsvrgb_mix
// Forms the high, low and ramp levels, routes them to red, green and blue by
// sector, then scales each channel by 255 into the output register.
// ----------------------------------------------------------------------------
module hsvrgb_mix #(
    parameter int HUE_WIDTH       = hsvrgb_pkg::HUE_WIDTH_DEF,
    parameter int LEVEL_FRAC_BITS = hsvrgb_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  hsvrgb_pkg::t_sector                    i_sector,
    input  logic [LEVEL_FRAC_BITS:0]               i_bri,
    input  logic [2*LEVEL_FRAC_BITS+1:0]           i_vs,
    input  logic [2*LEVEL_FRAC_BITS+HUE_WIDTH:0]   i_prod_up,
    input  logic [2*LEVEL_FRAC_BITS+HUE_WIDTH:0]   i_prod_down,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output hsvrgb_pkg::t_color                     o_red,
    output hsvrgb_pkg::t_color                     o_green,
    output hsvrgb_pkg::t_color                     o_blue
);
    import hsvrgb_pkg::*;

    localparam int SHIFT = 2*LEVEL_FRAC_BITS + HUE_WIDTH;
    localparam int NW    = SHIFT + 1;

    function automatic logic [NW-1:0] pick_level(
        t_src src, logic [NW-1:0] hi, logic [NW-1:0] lo,
        logic [NW-1:0] up, logic [NW-1:0] down
    );
        logic [NW-1:0] lvl;
        unique case (src)
            SRC_HI:   lvl = hi;
            SRC_LO:   lvl = lo;
            SRC_UP:   lvl = up;
            SRC_DOWN: lvl = down;
        endcase
        return lvl;
    endfunction

    // 255 * num as (num << 8) - num, keep the integer part
    function automatic t_color scale_level(logic [NW-1:0] num);
        logic [NW+COLOR_WIDTH-1:0] prod;
        prod = {num, {COLOR_WIDTH{1'b0}}} - {{COLOR_WIDTH{1'b0}}, num};
        return prod[SHIFT +: COLOR_WIDTH];
    endfunction

    logic [NW-1:0] w_num_hi;
    logic [NW-1:0] w_vs_full;
    logic [NW-1:0] w_num_lo;
    logic [NW-1:0] w_num_up;
    logic [NW-1:0] w_num_down;
    t_src_sel      w_sel;
    logic [NW-1:0] n_c_red;
    logic [NW-1:0] n_c_green;
    logic [NW-1:0] n_c_blue;

    logic          w_c_ready;
    logic          w_d_ready;
    logic          r_c_valid;
    logic [NW-1:0] r_c_red;
    logic [NW-1:0] r_c_green;
    logic [NW-1:0] r_c_blue;
    logic          r_d_valid;
    t_color        r_d_red;
    t_color        r_d_green;
    t_color        r_d_blue;

    assign w_num_hi   = {i_bri, {(SHIFT-LEVEL_FRAC_BITS){1'b0}}};
    assign w_vs_full  = NW'({i_vs, {HUE_WIDTH{1'b0}}});
    assign w_num_lo   = w_num_hi - w_vs_full;
    assign w_num_up   = w_num_hi - i_prod_up;
    assign w_num_down = w_num_hi - i_prod_down;

    assign w_sel     = sector_sources(i_sector);
    assign n_c_red   = pick_level(w_sel.red,   w_num_hi, w_num_lo, w_num_up, w_num_down);
    assign n_c_green = pick_level(w_sel.green, w_num_hi, w_num_lo, w_num_up, w_num_down);
    assign n_c_blue  = pick_level(w_sel.blue,  w_num_hi, w_num_lo, w_num_up, w_num_down);

    assign w_d_ready = !r_d_valid || i_ready;
    assign w_c_ready = !r_c_valid || w_d_ready;
    assign o_ready   = w_c_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_c_ready) begin
                r_c_valid <= i_valid;
            end
            if (w_d_ready) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ready && i_valid) begin
            r_c_red   <= n_c_red;
            r_c_green <= n_c_green;
            r_c_blue  <= n_c_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d_ready && r_c_valid) begin
            r_d_red   <= scale_level(r_c_red);
            r_d_green <= scale_level(r_c_green);
            r_d_blue  <= scale_level(r_c_blue);
        end
    end

    assign o_valid = r_d_valid;
    assign o_red   = r_d_red;
    assign o_green = r_d_green;
    assign o_blue  = r_d_blue;
endmodule
